### rtl/core/rsa_pkg.sv
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared widths, command and status codes, and the divider response type
// of the RPN stack ALU.
// ----------------------------------------------------------------------------
package rsa_pkg;

  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;
  localparam int STATUS_W  = 3;
  localparam int DIV_CNT_W = $clog2(DATA_W);

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [DATA_W-1:0]   word_t;

  localparam cmd_t CMD_ADD  = 3'd0;
  localparam cmd_t CMD_SUB  = 3'd1;
  localparam cmd_t CMD_MUL  = 3'd2;
  localparam cmd_t CMD_DIV  = 3'd3;
  localparam cmd_t CMD_PUSH = 3'd4;
  localparam cmd_t CMD_POP  = 3'd5;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_UNDER   = 3'd1;
  localparam status_t ST_DIVZERO = 3'd2;
  localparam status_t ST_EMPTY   = 3'd3;
  localparam status_t ST_OVER    = 3'd4;

  typedef struct packed {
    logic  done;
    word_t quotient;
  } div_rsp_t;

endpackage

### rtl/core/rsa_if.sv
// ----------------------------------------------------------------------------
// rsa_if
// Request and result channels of the RPN stack ALU (valid/ready).
// ----------------------------------------------------------------------------
interface rsa_in_if import rsa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  cmd_t                     cmd;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface rsa_out_if import rsa_pkg::*; #(
  parameter int CNT_W = 7
) ();
  logic                     valid;
  logic                     ready;
  status_t                  status;
  logic signed [DATA_W-1:0] popped_value;
  logic [CNT_W-1:0]         depth;

  modport source (output valid, output status, output popped_value, output depth,
                  input ready);
  modport sink   (input valid, input status, input popped_value, input depth,
                  output ready);
endinterface

### rtl/core/rsa_div.sv
// ----------------------------------------------------------------------------
// rsa_div
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero. The caller never starts it with a zero divisor.
// ----------------------------------------------------------------------------
module rsa_div import rsa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  word_t    num,
  input  word_t    den,
  output div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 neg_r, neg_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  word_t                quo_r, quo_nxt;
  word_t                rem_r, rem_nxt;
  word_t                den_r, den_nxt;
  logic [DATA_W:0]      rem_sh;
  logic [DATA_W:0]      diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    rem_sh   = {rem_r, quo_r[DATA_W-1]};
    diff     = rem_sh - {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = num[DATA_W-1] ^ den[DATA_W-1];
      // Two's-complement magnitude; the most negative value maps to itself,
      // which is its correct unsigned magnitude.
      quo_nxt  = num[DATA_W-1] ? (~num + word_t'(1)) : num;
      den_nxt  = den[DATA_W-1] ? (~den + word_t'(1)) : den;
      rem_nxt  = '0;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      if (!diff[DATA_W]) begin
        rem_nxt = diff[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? (~quo_r + word_t'(1)) : quo_r;

endmodule

### rtl/core/rpn_stack_alu_unit.sv
// ----------------------------------------------------------------------------
// rpn_stack_alu_unit
// Reverse-Polish integer stack machine with a memory-held operand stack.
// ----------------------------------------------------------------------------
// Each request is one command (add, sub, mul, div, push, pop) and yields one
// result carrying a status code, the popped value and the stack depth after
// the command. The stack lives in a single-port-write, registered-read
// memory of STACK_DEPTH words; the depth counter is reset to zero, so the
// memory itself needs no clearing. Requests are handled one at a time: push,
// failed commands and unknown codes go to the result stage, pop reads the
// top entry, add/sub/mul read two entries and write back, a zero-divisor
// divide ends after both reads, and a divide runs the 32-step shift-subtract
// divider before write-back. The next request is taken the cycle after the
// result is registered, even while that result still waits to be taken; the
// block then stalls at its end until the result register frees up.
module rpn_stack_alu_unit import rsa_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  rsa_in_if.sink           in_if,
  rsa_out_if.source        out_if
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD_S = 7'b0000010,
    S_EXEC = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_WB   = 7'b0010000,
    S_POP  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [CW-1:0] count_r, count_nxt;
  word_t         t_r, t_nxt;
  word_t         res_r, res_nxt;
  status_t       st_r, st_nxt;
  word_t         pop_r, pop_nxt;
  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  word_t         out_pop_r, out_pop_nxt;
  logic [CW-1:0] out_depth_r, out_depth_nxt;

  word_t         mem [STACK_DEPTH];
  word_t         rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  word_t         mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;
  word_t         mul_lo;
  logic          div_start;
  div_rsp_t      div_rsp;

  assign cnt_m1 = count_r - CW'(1);
  assign cnt_m2 = count_r - CW'(2);
  assign mul_lo = rd_data_r * t_r;

  rsa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (t_r),
    .den   (rd_data_r),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    count_nxt      = count_r;
    t_nxt          = t_r;
    res_nxt        = res_r;
    st_nxt         = st_r;
    pop_nxt        = pop_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_pop_nxt    = out_pop_r;
    out_depth_nxt  = out_depth_r;
    mem_we         = 1'b0;
    mem_waddr      = cnt_m2[AW-1:0];
    mem_wdata      = res_r;
    mem_re         = 1'b0;
    mem_raddr      = cnt_m1[AW-1:0];
    div_start      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          cmd_nxt   = in_if.cmd;
          st_nxt    = ST_OK;
          pop_nxt   = '0;
          state_nxt = S_DONE;
          unique case (in_if.cmd) inside
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
              if (count_r < CW'(2)) begin
                st_nxt = ST_UNDER;
              end else begin
                // Fetch the top entry now, the second one next cycle.
                mem_re    = 1'b1;
                state_nxt = S_RD_S;
              end
            end
            CMD_PUSH: begin
              if (count_r == CW'(STACK_DEPTH)) begin
                st_nxt = ST_OVER;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r[AW-1:0];
                mem_wdata = in_if.push_value;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_POP: begin
              if (count_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                state_nxt = S_POP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        pop_nxt   = rd_data_r;
        count_nxt = cnt_m1;
        state_nxt = S_DONE;
      end
      S_RD_S: begin
        t_nxt     = rd_data_r;
        mem_re    = 1'b1;
        mem_raddr = cnt_m2[AW-1:0];
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // Read data now holds the second entry; t_r holds the top.
        state_nxt = S_WB;
        case (cmd_r)
          CMD_ADD: res_nxt = rd_data_r + t_r;
          CMD_SUB: res_nxt = rd_data_r - t_r;
          CMD_MUL: res_nxt = mul_lo;
          default: begin
            if (rd_data_r == '0) begin
              st_nxt    = ST_DIVZERO;
              count_nxt = cnt_m2;
              state_nxt = S_DONE;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_nxt   = div_rsp.quotient;
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        mem_we    = 1'b1;
        count_nxt = cnt_m1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_pop_nxt    = pop_r;
          out_depth_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // A write always lands in an earlier cycle than any read of the same
  // entry, so the memory needs no bypass path.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    t_r          <= t_nxt;
    res_r        <= res_nxt;
    st_r         <= st_nxt;
    pop_r        <= pop_nxt;
    out_status_r <= out_status_nxt;
    out_pop_r    <= out_pop_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  assign in_if.ready         = (state_r == S_IDLE);
  assign out_if.valid        = out_valid_r;
  assign out_if.status       = out_status_r;
  assign out_if.popped_value = out_pop_r;
  assign out_if.depth        = out_depth_r;

endmodule
